[hw/rtl/thread_slot_scheduler_top_macros.svh]
// Assertion macros for the thread slot scheduler checker.
`ifndef THREAD_SLOT_SCHEDULER_TOP_MACROS_SVH
`define THREAD_SLOT_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TSS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thread slot scheduler check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TSS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thread slot scheduler check failed");

`endif

[hw/rtl/tss_pkg.sv]
// Shared types and codes for the thread slot scheduler.
package tss_pkg;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_RUNNING = 2'd1,
    SLOT_READY   = 2'd2,
    SLOT_KILLED  = 2'd3
  } slot_state_t;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_YIELD  = 3'd1;
  localparam logic [2:0] CMD_EXIT   = 3'd2;
  localparam logic [2:0] CMD_KILL   = 3'd3;
  localparam logic [2:0] CMD_QUERY  = 3'd4;

  localparam logic [1:0] KIND_NAMED = 2'd0;
  localparam logic [1:0] KIND_SELF  = 2'd1;
  localparam logic [1:0] KIND_ANY   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOFREE    = 3'd2;
  localparam logic [2:0] ST_NONEREADY = 3'd3;
  localparam logic [2:0] ST_FAILED    = 3'd4;

endpackage

[hw/rtl/tss_in_if.sv]
// Command channel interface of the thread slot scheduler.
interface tss_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [1:0]        target_kind;
  logic signed [7:0] target_id;

  modport source (output valid, command, target_kind, target_id, input ready);
  modport sink (input valid, command, target_kind, target_id, output ready);
endinterface

[hw/rtl/tss_out_if.sv]
// Result channel interface of the thread slot scheduler.
interface tss_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status_code;
  logic [5:0] result_id;

  modport source (output valid, status_code, result_id, input ready);
  modport sink (input valid, status_code, result_id, output ready);
endinterface

[hw/rtl/thread_slot_scheduler_top.sv]
// Thread slot scheduler: sequencer that scans the slot table one entry per cycle.
//
//   channel | direction | fields
//   in_ch   | sink      | command[2:0], target_kind[1:0], target_id[7:0] signed
//   out_ch  | source    | status_code[2:0], result_id[5:0]
//
// After an item is accepted, the table is scanned through its single read port (S_SCAN),
// then one decision state (S_DECIDE) and one output state (S_OUT) produce the result.
// A thread switch adds a second sweep (S_REL) that frees killed slots and two table writes;
// an exit adds only its second write. Reset is synchronous; slot 0 is running and all
// other slots are empty. A new item is accepted while a result waits in the output
// register; the sequencer then holds its result until that register is free.
module thread_slot_scheduler_top
  import tss_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  tss_in_if.sink       in_ch,
  tss_out_if.source    out_ch
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [8:0] SLOTS_LIM = 9'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_REL,
    S_SW1,
    S_SW2,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  pidx_r;
  logic              pend_r;
  logic              fe_ok_r;
  logic [IDX_W-1:0]  fe_r;
  logic              fr_ok_r;
  logic [IDX_W-1:0]  fr_r;
  slot_state_t       tstat_r;
  logic [2:0]        cmd_r;
  logic [1:0]        kind_r;
  logic signed [7:0] tid_r;
  logic [IDX_W-1:0]  cur_r;
  logic [IDX_W-1:0]  nxt_id_r;
  logic [2:0]        res_st_r;
  logic [IDX_W-1:0]  res_id_r;
  logic              out_valid_r;
  logic [2:0]        out_st_r;
  logic [5:0]        out_id_r;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  slot_state_t       wr_data;
  logic [IDX_W-1:0]  rd_addr;
  slot_state_t       rd_data;
  logic              issue;
  logic              last;
  logic              tid_ok;
  logic [IDX_W-1:0]  tid_idx;
  logic [7:0]        res_wide;
  logic              out_load;

  logic [2:0]        dec_st;
  logic [IDX_W-1:0]  dec_id;
  logic              dec_wr;
  logic [IDX_W-1:0]  dec_addr;
  slot_state_t       dec_data;
  logic [IDX_W-1:0]  dec_sw_id;
  state_t            dec_next;

  tss_table #(.SLOTS(SLOTS)) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_addr  = cnt_r[IDX_W-1:0];
  assign issue    = (cnt_r != CNT_SLOTS);
  assign last     = pend_r && (pidx_r == LAST_IDX);
  assign tid_ok   = !tid_r[7] && ({1'b0, $unsigned(tid_r)} < SLOTS_LIM);
  assign tid_idx  = tid_r[IDX_W-1:0];
  assign res_wide = 8'(res_id_r);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready        = rst_n && (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status_code = out_st_r;
  assign out_ch.result_id   = out_id_r;

  always_comb begin
    dec_st    = ST_INVALID;
    dec_id    = '0;
    dec_wr    = 1'b0;
    dec_addr  = cur_r;
    dec_data  = SLOT_EMPTY;
    dec_sw_id = cur_r;
    dec_next  = S_OUT;
    unique case (cmd_r)
      CMD_CREATE: begin
        if (fe_ok_r) begin
          dec_st   = ST_OK;
          dec_id   = fe_r;
          dec_wr   = 1'b1;
          dec_addr = fe_r;
          dec_data = SLOT_READY;
        end else begin
          dec_st = ST_NOFREE;
        end
      end
      CMD_YIELD: begin
        priority if (kind_r == KIND_SELF ||
                     (kind_r == KIND_NAMED && tid_ok && tid_idx == cur_r)) begin
          dec_st = ST_OK;
          dec_id = cur_r;
        end else if (kind_r == KIND_ANY) begin
          if (fr_ok_r) begin
            dec_st    = ST_OK;
            dec_id    = fr_r;
            dec_sw_id = fr_r;
            dec_next  = S_REL;
          end else begin
            dec_st = ST_NONEREADY;
          end
        end else if (kind_r == KIND_NAMED && tid_ok && tstat_r == SLOT_READY) begin
          dec_st    = ST_OK;
          dec_id    = tid_idx;
          dec_sw_id = tid_idx;
          dec_next  = S_REL;
        end else begin
          dec_st = ST_INVALID;
        end
      end
      CMD_EXIT: begin
        if (fr_ok_r) begin
          dec_st    = ST_OK;
          dec_id    = fr_r;
          dec_wr    = 1'b1;
          dec_addr  = cur_r;
          dec_data  = SLOT_KILLED;
          dec_sw_id = fr_r;
          dec_next  = S_SW2;
        end else begin
          dec_st = ST_NONEREADY;
        end
      end
      CMD_KILL: begin
        if (tid_ok && (tstat_r == SLOT_READY || tstat_r == SLOT_KILLED)) begin
          dec_st   = ST_OK;
          dec_id   = tid_idx;
          dec_wr   = 1'b1;
          dec_addr = tid_idx;
          dec_data = SLOT_EMPTY;
        end else begin
          dec_st = ST_INVALID;
        end
      end
      CMD_QUERY: begin
        dec_st = ST_OK;
        dec_id = cur_r;
      end
      default: begin
        dec_st = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = SLOT_EMPTY;
    unique case (state_r)
      S_DECIDE: begin
        wr_en   = dec_wr;
        wr_addr = dec_addr;
        wr_data = dec_data;
      end
      S_REL: begin
        wr_en   = pend_r && (rd_data == SLOT_KILLED);
        wr_addr = pidx_r;
        wr_data = SLOT_EMPTY;
      end
      S_SW1: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = SLOT_READY;
      end
      S_SW2: begin
        wr_en   = 1'b1;
        wr_addr = nxt_id_r;
        wr_data = SLOT_RUNNING;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r   <= in_ch.command;
            kind_r  <= in_ch.target_kind;
            tid_r   <= in_ch.target_id;
            fe_ok_r <= 1'b0;
            fr_ok_r <= 1'b0;
            tstat_r <= SLOT_EMPTY;
            cnt_r   <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN, S_REL: begin
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
          end
          pend_r <= issue;
          pidx_r <= cnt_r[IDX_W-1:0];
          if (state_r == S_SCAN && pend_r) begin
            if (rd_data == SLOT_EMPTY && !fe_ok_r) begin
              fe_ok_r <= 1'b1;
              fe_r    <= pidx_r;
            end
            if (rd_data == SLOT_READY && !fr_ok_r) begin
              fr_ok_r <= 1'b1;
              fr_r    <= pidx_r;
            end
            if (pidx_r == tid_idx) begin
              tstat_r <= rd_data;
            end
          end
          if (last) begin
            state_r <= (state_r == S_SCAN) ? S_DECIDE : S_SW1;
          end
        end
        S_DECIDE: begin
          res_st_r <= dec_st;
          res_id_r <= dec_id;
          nxt_id_r <= dec_sw_id;
          cnt_r    <= '0;
          pend_r   <= 1'b0;
          state_r  <= dec_next;
        end
        S_SW1: begin
          state_r <= S_SW2;
        end
        S_SW2: begin
          cur_r   <= nxt_id_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_st_r <= res_st_r;
            out_id_r <= res_wide[5:0];
            state_r  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/tss_table.sv]
// Slot status memory with one write port, one registered read port and valid bits.
module tss_table
  import tss_pkg::*;
#(
  parameter int SLOTS = 64,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_state_t      wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_state_t      rd_data
);

  slot_state_t      mem_r [SLOTS];
  logic [SLOTS-1:0] vld_r;
  slot_state_t      rd_q_r;
  logic             vld_q_r;
  logic             zero_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_q_r   <= mem_r[rd_addr];
    vld_q_r  <= vld_r[rd_addr];
    zero_q_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // An entry never written reads as its reset value.
  assign rd_data = vld_q_r ? rd_q_r : (zero_q_r ? SLOT_RUNNING : SLOT_EMPTY);

endmodule

[hw/rtl/tss_checker.sv]
// Port-level assertion checker for the thread slot scheduler and its bind.
`include "thread_slot_scheduler_top_macros.svh"

module tss_checker
  import tss_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status_code,
  input logic [5:0] out_result_id
);

  `TSS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TSS_ASSERT_IMP(a_id_zero, out_valid && out_status_code != ST_OK, out_result_id == 6'd0)
  `TSS_ASSERT_IMP(a_status_range, out_valid, out_status_code <= ST_FAILED)
  `TSS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind thread_slot_scheduler_top tss_checker u_tss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status_code (out_ch.status_code),
  .out_result_id   (out_ch.result_id)
);
